[src/cpio_pkg.sv]
// ----------------------------------------------------------------------------
// cpio_pkg
// Types and constants shared by the cpio newc header parser.
// ----------------------------------------------------------------------------
package cpio_pkg;

    localparam int unsigned HEADER_BYTES = 110;
    localparam int unsigned HEX_DIGITS   = 8;
    localparam int unsigned OFF_FILE     = 54;
    localparam int unsigned OFF_NAME     = 94;
    localparam int unsigned OFF_CHECK    = 102;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_NAME   = 3'b010,
        PH_PAD    = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NAME     = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_ERROR    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_MAGIC     = 2'd0,
        ERR_HEX       = 2'd1,
        ERR_NAME_ZERO = 2'd2
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  name_char;
        logic [31:0] name_length;
        logic [31:0] data_size;
        logic [31:0] check_value;
        err_t        error_code;
        logic        last;
    } result_t;

    // {valid, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

    // "07070" followed by '1' or '2'
    function automatic logic magic_ok(input logic [6:0] pos, input logic [7:0] c);
        logic ok;
        ok = 1'b1;
        unique case (pos)
            7'd0, 7'd2, 7'd4: ok = (c == 8'h30);
            7'd1, 7'd3:       ok = (c == 8'h37);
            7'd5:             ok = (c == 8'h31) || (c == 8'h32);
            default:          ok = 1'b1;
        endcase
        return ok;
    endfunction

endpackage

[src/cpio_newc_header_parser.sv]
// ----------------------------------------------------------------------------
// cpio_newc_header_parser
// Parses cpio newc entry headers from a byte stream, forwards each name.
// ----------------------------------------------------------------------------
// Input: one archive byte per beat on s_tdata. Output beats carry a result:
// a name byte, entry complete or error (kind on m_tuser). m_tlast marks the
// final result caused by one input byte. Size, name length and checksum
// ride on every result as decoded so far.
// One byte is taken every cycle while s_tready is high; a byte that causes
// two results (last name byte with no padding) needs two output beats, so
// throughput is one result per cycle at the master side while m_tready is
// high. Results go through a four-entry result queue; the slave side is
// ready while at least two entries are free, so a stalled receiver holds
// the queue and input back-pressures once more than two entries are used.
// Padding length per entry is worked out while the name size digits
// arrive, one four-step remainder update per digit.
// Reset clears the queue and returns the parser to the start of a header.
// ----------------------------------------------------------------------------
module cpio_newc_header_parser #(
    parameter int unsigned PAD_ALIGN = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] in_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // [7:0] name_char, [39:8] name_length,
                                    // [71:40] data_size, [103:72] check_value,
                                    // [105:104] error_code, rest zero
    output logic [1:0]   m_tuser,   // [1:0] out_kind
    output logic         m_tlast
);
    import cpio_pkg::*;

    localparam int unsigned PW    = (PAD_ALIGN > 1) ? $clog2(PAD_ALIGN) : 1;
    localparam int unsigned HMOD  = HEADER_BYTES % PAD_ALIGN;
    localparam logic [PW:0] A_W   = (PW + 1)'(PAD_ALIGN);
    localparam logic [PW:0] HM_W  = (PW + 1)'(HMOD);
    localparam int unsigned DEPTH = 4;

    phase_t        phase_reg,  phase_next;
    logic [6:0]    pos_reg,    pos_next;
    logic [31:0]   nrem_reg,   nrem_next;
    logic [PW-1:0] pad_reg,    pad_next;
    logic [PW-1:0] nmod_reg,   nmod_next;
    logic [31:0]   nsize_reg,  nsize_next;
    logic [31:0]   fsize_reg,  fsize_next;
    logic [31:0]   chk_reg,    chk_next;
    logic          magic_reg,  magic_next;
    logic          hex_reg,    hex_next;

    result_t       fifo_reg [DEPTH];
    logic [1:0]    wptr_reg, rptr_reg;
    logic [2:0]    count_reg;

    result_t       res0, res1;
    logic [1:0]    n_res;
    logic          accept, pop;
    logic [4:0]    hn;
    logic          in_file, in_name, in_chk;
    logic [PW:0]   t, s;

    assign accept = s_tvalid && s_tready;
    assign pop    = m_tvalid && m_tready;
    assign hn     = hex_nibble(s_tdata);
    assign in_file  = (pos_reg >= 7'(OFF_FILE))  && (pos_reg < 7'(OFF_FILE + HEX_DIGITS));
    assign in_name  = (pos_reg >= 7'(OFF_NAME))  && (pos_reg < 7'(OFF_NAME + HEX_DIGITS));
    assign in_chk   = (pos_reg >= 7'(OFF_CHECK)) && (pos_reg < 7'(OFF_CHECK + HEX_DIGITS));

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        nrem_next  = nrem_reg;
        pad_next   = pad_reg;
        nmod_next  = nmod_reg;
        nsize_next = nsize_reg;
        fsize_next = fsize_reg;
        chk_next   = chk_reg;
        magic_next = magic_reg;
        hex_next   = hex_reg;
        n_res      = 2'd0;
        t          = '0;
        s          = '0;
        res0       = '{kind: KIND_NAME, name_char: 8'd0, name_length: 32'd0,
                       data_size: 32'd0, check_value: 32'd0, error_code: ERR_MAGIC,
                       last: 1'b1};
        res1       = res0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (pos_reg == 7'd0)
                begin
                    nsize_next = 32'd0;
                    fsize_next = 32'd0;
                    chk_next   = 32'd0;
                    nmod_next  = '0;
                    magic_next = 1'b1;
                    hex_next   = 1'b1;
                end
                if (pos_reg < 7'd6)
                begin
                    if (!magic_ok(pos_reg, s_tdata))
                        magic_next = 1'b0;
                end
                else if (in_file || in_name || in_chk)
                begin
                    if (!hn[4])
                        hex_next = 1'b0;
                    if (in_file)
                        fsize_next = {fsize_next[27:0], hn[3:0]};
                    if (in_chk)
                        chk_next = {chk_next[27:0], hn[3:0]};
                    if (in_name)
                    begin
                        nsize_next = {nsize_next[27:0], hn[3:0]};
                        for (int i = 3; i >= 0; i--)
                        begin
                            t = {nmod_next, hn[i]};
                            if (t >= A_W)
                                t = t - A_W;
                            nmod_next = t[PW-1:0];
                        end
                    end
                end

                if (pos_reg == 7'(HEADER_BYTES - 1))
                begin
                    pos_next = 7'd0;
                    res0.kind        = KIND_ERROR;
                    res0.name_length = nsize_next;
                    res0.data_size   = fsize_next;
                    res0.check_value = chk_next;
                    priority if (!magic_next)
                    begin
                        res0.error_code = ERR_MAGIC;
                        n_res = 2'd1;
                    end
                    else if (!hex_next)
                    begin
                        res0.error_code = ERR_HEX;
                        n_res = 2'd1;
                    end
                    else if (nsize_next == 32'd0)
                    begin
                        res0.error_code = ERR_NAME_ZERO;
                        n_res = 2'd1;
                    end
                    else
                    begin
                        s = HM_W + {1'b0, nmod_next};
                        if (s >= A_W)
                            s = s - A_W;
                        pad_next   = (s == '0) ? '0 : PW'(A_W - s);
                        nrem_next  = nsize_next;
                        phase_next = PH_NAME;
                    end
                end
                else
                    pos_next = pos_reg + 7'd1;
            end
            PH_NAME:
            begin
                res0.name_length = nsize_reg;
                res0.data_size   = fsize_reg;
                res0.check_value = chk_reg;
                res1             = res0;
                res1.kind        = KIND_COMPLETE;
                res0.name_char   = s_tdata;
                if (nrem_reg <= 32'd1)
                begin
                    nrem_next = 32'd0;
                    if (pad_reg == '0)
                    begin
                        phase_next = PH_HEADER;
                        pos_next   = 7'd0;
                        if (s_tdata == 8'd0)
                        begin
                            res0  = res1;
                            n_res = 2'd1;
                        end
                        else
                        begin
                            res0.last = 1'b0;
                            n_res     = 2'd2;
                        end
                    end
                    else
                    begin
                        phase_next = PH_PAD;
                        n_res      = (s_tdata == 8'd0) ? 2'd0 : 2'd1;
                    end
                end
                else
                begin
                    nrem_next = nrem_reg - 32'd1;
                    n_res     = 2'd1;
                end
            end
            PH_PAD:
            begin
                if (pad_reg <= PW'(1))
                begin
                    pad_next         = '0;
                    phase_next       = PH_HEADER;
                    pos_next         = 7'd0;
                    res0.kind        = KIND_COMPLETE;
                    res0.name_length = nsize_reg;
                    res0.data_size   = fsize_reg;
                    res0.check_value = chk_reg;
                    n_res            = 2'd1;
                end
                else
                    pad_next = pad_reg - PW'(1);
            end
            default:
            begin
                phase_next = PH_HEADER;
                pos_next   = 7'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            pos_reg   <= 7'd0;
            nrem_reg  <= 32'd0;
            pad_reg   <= '0;
            nmod_reg  <= '0;
            nsize_reg <= 32'd0;
            fsize_reg <= 32'd0;
            chk_reg   <= 32'd0;
            magic_reg <= 1'b1;
            hex_reg   <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            nrem_reg  <= nrem_next;
            pad_reg   <= pad_next;
            nmod_reg  <= nmod_next;
            nsize_reg <= nsize_next;
            fsize_reg <= fsize_next;
            chk_reg   <= chk_next;
            magic_reg <= magic_next;
            hex_reg   <= hex_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && n_res != 2'd0)
            fifo_reg[wptr_reg] <= res0;
        if (accept && n_res == 2'd2)
            fifo_reg[wptr_reg + 2'd1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 2'd0;
            rptr_reg  <= 2'd0;
            count_reg <= 3'd0;
        end
        else
        begin
            if (accept)
                wptr_reg <= wptr_reg + n_res;
            if (pop)
                rptr_reg <= rptr_reg + 2'd1;
            count_reg <= count_reg + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
        end
    end

    assign s_tready = (count_reg <= 3'(DEPTH - 2));
    assign m_tvalid = (count_reg != 3'd0);
    assign m_tdata  = {6'd0, fifo_reg[rptr_reg].error_code, fifo_reg[rptr_reg].check_value,
                       fifo_reg[rptr_reg].data_size, fifo_reg[rptr_reg].name_length,
                       fifo_reg[rptr_reg].name_char};
    assign m_tuser  = fifo_reg[rptr_reg].kind;
    assign m_tlast  = fifo_reg[rptr_reg].last;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'(DEPTH))
        else $error("result queue overflow");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tlast)
        else $error("error result not marked last");

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_HEADER |-> pos_reg == 7'd0)
        else $error("header position not cleared outside header");

    a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAD |-> pad_reg != '0)
        else $error("pad phase with nothing to skip");

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cpio newc header parser.
// ----------------------------------------------------------------------------
// Archive bytes go in on the slave stream: well-formed entries with random
// sizes, names and padding, headers broken in the magic, in the hex fields or
// with a zero name size, and garbage headers. A predictor in the scoreboard
// tracks the parse state from every accepted byte and queues the results that
// it expects. Each result beat is checked against the oldest of them. Both
// sides stall in random bursts, apart from a steady stretch at the end.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cpio_pkg::*;

    localparam int unsigned PAD_ALIGN = 4;

    class header_scoreboard;
        result_t     expected_results[$];
        phase_t      phase;
        int unsigned hdr_pos;
        logic [31:0] name_left;
        int unsigned pad_left;
        logic [31:0] name_acc;
        logic [31:0] size_acc;
        logic [31:0] sum_acc;
        bit          magic_good;
        bit          hex_good;
        int          failures;
        int          name_beats;
        int          entries_done;
        int          errors_seen[3];

        function new();
            phase      = PH_HEADER;
            hdr_pos    = 0;
            name_left  = '0;
            pad_left   = 0;
            name_acc   = '0;
            size_acc   = '0;
            sum_acc    = '0;
            magic_good = 1'b1;
            hex_good   = 1'b1;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function bit decode_digit(input logic [7:0] c, output logic [3:0] v);
            v = 4'd0;
            if (c >= "0" && c <= "9")
                v = 4'(c - "0");
            else if (c >= "A" && c <= "F")
                v = 4'(c - "A" + 8'd10);
            else if (c >= "a" && c <= "f")
                v = 4'(c - "a" + 8'd10);
            else
                return 1'b0;
            return 1'b1;
        endfunction

        function result_t make(input kind_t k, input logic [7:0] ch, input err_t e);
            result_t r;
            r.kind        = k;
            r.name_char   = ch;
            r.name_length = name_acc;
            r.data_size   = size_acc;
            r.check_value = sum_acc;
            r.error_code  = e;
            r.last        = 1'b0;
            return r;
        endfunction

        function void note_byte(input logic [7:0] b);
            result_t         r[2];
            int              n;
            int unsigned     p;
            logic [3:0]      nib;
            bit              final_byte;
            longint unsigned total;
            n = 0;
            case (phase)
                PH_HEADER:
                begin
                    p = hdr_pos;
                    if (p == 0)
                    begin
                        name_acc   = '0;
                        size_acc   = '0;
                        sum_acc    = '0;
                        magic_good = 1'b1;
                        hex_good   = 1'b1;
                    end
                    if (p < 5)
                    begin
                        if (b != ((p % 2) ? "7" : "0"))
                            magic_good = 1'b0;
                    end
                    else if (p == 5)
                    begin
                        if (b != "1" && b != "2")
                            magic_good = 1'b0;
                    end
                    else if (p >= OFF_FILE && p < OFF_FILE + HEX_DIGITS)
                    begin
                        if (!decode_digit(b, nib))
                            hex_good = 1'b0;
                        size_acc = {size_acc[27:0], nib};
                    end
                    else if (p >= OFF_NAME && p < OFF_NAME + HEX_DIGITS)
                    begin
                        if (!decode_digit(b, nib))
                            hex_good = 1'b0;
                        name_acc = {name_acc[27:0], nib};
                    end
                    else if (p >= OFF_CHECK && p < OFF_CHECK + HEX_DIGITS)
                    begin
                        if (!decode_digit(b, nib))
                            hex_good = 1'b0;
                        sum_acc = {sum_acc[27:0], nib};
                    end

                    if (p + 1 >= HEADER_BYTES)
                    begin
                        hdr_pos = 0;
                        if (!magic_good)
                        begin
                            r[n] = make(KIND_ERROR, 8'h00, ERR_MAGIC);
                            n++;
                        end
                        else if (!hex_good)
                        begin
                            r[n] = make(KIND_ERROR, 8'h00, ERR_HEX);
                            n++;
                        end
                        else if (name_acc == 0)
                        begin
                            r[n] = make(KIND_ERROR, 8'h00, ERR_NAME_ZERO);
                            n++;
                        end
                        else
                        begin
                            // 33-bit sum, name size may be near 2^32
                            total     = 64'(HEADER_BYTES) + 64'(name_acc);
                            name_left = name_acc;
                            pad_left  = int'((PAD_ALIGN - total % PAD_ALIGN) % PAD_ALIGN);
                            phase     = PH_NAME;
                        end
                    end
                    else
                        hdr_pos = p + 1;
                end
                PH_NAME:
                begin
                    final_byte = (name_left <= 1);
                    name_left  = final_byte ? 32'd0 : name_left - 1;
                    if (!(final_byte && b == 8'h00))
                    begin
                        r[n] = make(KIND_NAME, b, ERR_MAGIC);
                        n++;
                    end
                    if (final_byte)
                    begin
                        if (pad_left == 0)
                        begin
                            r[n] = make(KIND_COMPLETE, 8'h00, ERR_MAGIC);
                            n++;
                            phase   = PH_HEADER;
                            hdr_pos = 0;
                        end
                        else
                            phase = PH_PAD;
                    end
                end
                default:
                begin
                    if (pad_left <= 1)
                    begin
                        pad_left = 0;
                        r[n] = make(KIND_COMPLETE, 8'h00, ERR_MAGIC);
                        n++;
                        phase   = PH_HEADER;
                        hdr_pos = 0;
                    end
                    else
                        pad_left--;
                end
            endcase
            if (n > 0)
                r[n-1].last = 1'b1;
            for (int i = 0; i < n; i++)
                expected_results.push_back(r[i]);
        endfunction

        function void flag(input string msg);
            failures++;
            if (failures <= 10)
                $display("%s", msg);
        endfunction

        function void check_result(input logic [1:0] kind, input logic [111:0] data,
                                   input logic lst);
            result_t want;
            if (expected_results.size() == 0)
            begin
                flag($sformatf("%0t: result with nothing expected: kind %0d tdata %h last %b",
                               $time, kind, data, lst));
                return;
            end
            want = expected_results.pop_front();
            if (kind !== want.kind || data[7:0] !== want.name_char
                    || data[39:8] !== want.name_length || data[71:40] !== want.data_size
                    || data[103:72] !== want.check_value || data[105:104] !== want.error_code
                    || data[111:106] !== 6'd0 || lst !== want.last)
                flag($sformatf({"%0t: mismatch\n  exp kind %0d char %h len %h size %h sum %h",
                                " err %0d last %b\n  got kind %0d char %h len %h size %h",
                                " sum %h err %0d last %b pad %h"},
                               $time, want.kind, want.name_char, want.name_length,
                               want.data_size, want.check_value, want.error_code, want.last,
                               kind, data[7:0], data[39:8], data[71:40], data[103:72],
                               data[105:104], lst, data[111:106]));
            case (want.kind)
                KIND_NAME:     name_beats++;
                KIND_COMPLETE: entries_done++;
                default:       errors_seen[want.error_code]++;
            endcase
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    header_scoreboard sb = new();

    logic [7:0]  hdr [HEADER_BYTES];
    bit          no_idle = 1'b0;
    int unsigned tx_rate = 0;
    int unsigned rx_rate = 0;
    int          bytes_sent = 0;

    cpio_newc_header_parser #(
        .PAD_ALIGN (PAD_ALIGN)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("** cpio_newc_header_parser: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // receiver: stall rate is redrawn per window, off for the final stretch
    initial
    begin
        int stall;
        int window;
        stall    = 0;
        window   = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (window == 0)
            begin
                window = 200;
                case ($urandom_range(0, 2))
                    0:       rx_rate = 0;
                    1:       rx_rate = 4;
                    default: rx_rate = 12;
                endcase
            end
            window--;
            if (no_idle || rx_rate == 0)
            begin
                stall    = 0;
                m_tready = 1'b1;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready = 1'b0;
            end
            else if ($urandom_range(0, rx_rate - 1) == 0)
            begin
                stall    = $urandom_range(0, 18);
                m_tready = 1'b0;
            end
            else
                m_tready = 1'b1;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 10)
            return 8'("0") + 8'(v);
        return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while ((c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f"));
        return c;
    endfunction

    function automatic void set_field(input int unsigned off, input logic [31:0] v);
        for (int d = 0; d < HEX_DIGITS; d++)
            hdr[off + d] = hex_char(v[4 * (7 - d) +: 4], 1'($urandom_range(0, 1)));
    endfunction

    function automatic void build_header(input logic [31:0] fsize, input logic [31:0] nsize,
                                         input logic [31:0] csum, input logic [7:0] sub);
        for (int i = 0; i < HEADER_BYTES; i++)
            hdr[i] = 8'($urandom_range(0, 255));
        for (int i = 0; i < 5; i++)
            hdr[i] = (i % 2) ? "7" : "0";
        hdr[5] = sub;
        set_field(OFF_FILE, fsize);
        set_field(OFF_NAME, nsize);
        set_field(OFF_CHECK, csum);
    endfunction

    task automatic idle_for(input int n);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (!no_idle && tx_rate != 0 && $urandom_range(0, tx_rate - 1) == 0)
            idle_for($urandom_range(1, 19));
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_header();
        for (int i = 0; i < HEADER_BYTES; i++)
            send_byte(hdr[i]);
    endtask

    task automatic send_name(input int unsigned len, input bit nul_end);
        logic [7:0] b;
        for (int unsigned i = 0; i < len; i++)
        begin
            b = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
            if (i == len - 1 && nul_end)
                b = 8'h00;
            send_byte(b);
        end
    endtask

    task automatic send_entry(input logic [31:0] fsize, input logic [31:0] nsize,
                              input logic [31:0] csum, input logic [7:0] sub,
                              input bit nul_end);
        int unsigned pad;
        pad = (PAD_ALIGN - (HEADER_BYTES + nsize) % PAD_ALIGN) % PAD_ALIGN;
        build_header(fsize, nsize, csum, sub);
        send_header();
        send_name(nsize, nul_end);
        repeat (pad) send_byte(8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int          start;
        int          pick;
        int unsigned nsize;
        logic [7:0]  sub;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        tx_rate = 8;
        // size extremes; lone NUL name with one pad byte
        send_entry(32'h0000_0000, 32'd1, 32'h0000_0000, "1", 1'b1);
        // name ends on the boundary: name beat and completion from one byte unless it is NUL
        send_entry(32'hFFFF_FFFF, 32'd2, 32'hFFFF_FFFF, "2", 1'b0);
        // boundary again, dropped NUL leaves the completion alone
        send_entry(32'h1234_ABCD, 32'd6, 32'hDEAD_BEEF, "1", 1'b1);
        // three pad bytes
        send_entry(32'h00C0_FFEE, 32'd3, 32'h8000_0001, "2", 1'b0);
        // bad magic outranks bad hex
        build_header(32'h0000_0010, 32'd4, 32'h0000_0020, "1");
        hdr[1]         = "8";
        hdr[OFF_CHECK] = "g";
        send_header();
        // bad subtype digit
        build_header(32'h0000_0001, 32'd9, 32'h0000_0002, "3");
        send_header();
        // bad hex outranks zero name size; bad digit counts as zero
        build_header(32'h5555_5555, 32'd0, 32'hA5A5_A5A5, "2");
        hdr[OFF_FILE + 7] = 8'hC6;
        send_header();
        // zero name size
        build_header(32'h0BAD_F00D, 32'd0, 32'h0000_FFFF, "1");
        send_header();

        idle_for(1);
        while (sb.pending() != 0)
            @(posedge clk);

        start = bytes_sent;
        while (bytes_sent - start < 200)
        begin
            if (bytes_sent - start > 120)
                no_idle = 1'b1;
            case ($urandom_range(0, 2))
                0:       tx_rate = 0;
                1:       tx_rate = 6;
                default: tx_rate = 20;
            endcase
            pick  = $urandom_range(0, 99);
            nsize = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                 : $urandom_range(13, 120);
            sub   = $urandom_range(0, 1) ? "2" : "1";
            if (pick < 72)
                send_entry($urandom(), nsize, $urandom(), sub, 1'($urandom_range(0, 1)));
            else if (pick < 90)
            begin
                build_header($urandom(), nsize, $urandom(), sub);
                repeat ($urandom_range(1, 2))
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            pick      = $urandom_range(0, 5);
                            hdr[pick] = hdr[pick] ^ 8'($urandom_range(1, 255));
                        end
                        1:
                        begin
                            case ($urandom_range(0, 2))
                                0:       pick = OFF_FILE;
                                1:       pick = OFF_NAME;
                                default: pick = OFF_CHECK;
                            endcase
                            hdr[pick + $urandom_range(0, 7)] = non_hex();
                        end
                        default: set_field(OFF_NAME, 32'd0);
                    endcase
                send_header();
            end
            else
                for (int i = 0; i < HEADER_BYTES; i++)
                    send_byte(8'($urandom_range(0, 255)));
        end

        // huge name size: padding from the 33-bit sum, name runs past the end
        no_idle = 1'b1;
        build_header($urandom(), 32'hFFFF_FFFF - $urandom_range(0, 3), $urandom(), "1");
        send_header();
        send_name(40, 1'b0);

        idle_for(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d bytes in, %0d name beats, %0d entries",
                 bytes_sent, sb.name_beats, sb.entries_done);
        $display("errors magic/hex/zero name %0d/%0d/%0d, %0d failures",
                 sb.errors_seen[ERR_MAGIC], sb.errors_seen[ERR_HEX],
                 sb.errors_seen[ERR_NAME_ZERO], sb.failures);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("** cpio_newc_header_parser: PASSED **");
        else
            $display("** cpio_newc_header_parser: FAILED **");
        $finish;
    end

endmodule

[cpio_newc_header_parser.f]
src/cpio_pkg.sv
src/cpio_newc_header_parser.sv
sim/tb_top.sv
